/* rtl/dnle_pkg.sv */
// Shared types and constants for the DNS name label encoder.
`default_nettype none

package dnle_pkg;

  // Request command codes
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Label separator character
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Terminator byte value
  localparam logic [7:0] TERM_BYTE = 8'h00;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_CHR,
    ST_TERM
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_char;    // store accepted character
    logic set_err;    // flag empty or overlong label
    logic load_len;   // send length byte, start store readout
    logic load_chr;   // send next stored character
    logic load_term;  // send terminator, clear label and error
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_dot;     // incoming character is a separator
    logic cnt_zero;   // label is empty
    logic cnt_full;   // label holds the maximum length
    logic idx_last;   // readout is at the final stored character
    logic out_free;   // output register can take a new result
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/dnle_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module dnle_ram #(
  parameter int Width = 8,
  parameter int Depth = 62
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/dnle_dp.sv */
// Datapath: label store, count, readout index, error flag and output register.
`default_nettype none

module dnle_dp #(
  parameter int MaxLabel = 62
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         char_in_i,
  input  wire dnle_pkg::dp_cmd_t  cmd_i,
  output dnle_pkg::dp_stat_t      stat_o,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output logic [7:0]              out_byte_o,
  output logic                    is_last_o,
  output logic                    name_error_o
);

  import dnle_pkg::*;

  localparam int AW = (MaxLabel > 1) ? $clog2(MaxLabel) : 1;
  localparam int CW = $clog2(MaxLabel + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxLabel);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          err_q, err_d;
  logic          ovld_q, ovld_d;
  logic [7:0]    obyte_q, obyte_d;
  logic          olast_q, olast_d;
  logic          oerr_q, oerr_d;

  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [AW-1:0] idx_inc;

  assign idx_inc = idx_q + AW'(1);

  // Status toward the controller
  always_comb begin
    stat_o.is_dot   = (char_in_i == DOT_CHAR);
    stat_o.cnt_zero = (cnt_q == '0);
    stat_o.cnt_full = (cnt_q >= MaxCnt);
    stat_o.idx_last = ((CW'(idx_q) + CW'(1)) == cnt_q);
    stat_o.out_free = !ovld_q || !out_stall_i;
  end

  // Label store
  dnle_ram #(
    .Width (8),
    .Depth (MaxLabel)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_char),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (char_in_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state of count, index, error and output register
  always_comb begin
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    err_d     = err_q;
    ovld_d    = ovld_q && out_stall_i;
    obyte_d   = obyte_q;
    olast_d   = olast_q;
    oerr_d    = oerr_q;
    ram_re    = 1'b0;
    ram_raddr = '0;

    // Collect characters
    if (cmd_i.wr_char) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.set_err) begin
      err_d = 1'b1;
    end

    // Send length byte and fetch the first character
    if (cmd_i.load_len) begin
      ovld_d    = 1'b1;
      obyte_d   = 8'(cnt_q);
      olast_d   = 1'b0;
      oerr_d    = 1'b0;
      idx_d     = '0;
      ram_re    = 1'b1;
      ram_raddr = '0;
    end

    // Send a stored character and prefetch the next one
    if (cmd_i.load_chr) begin
      ovld_d  = 1'b1;
      obyte_d = ram_rdata;
      olast_d = 1'b0;
      oerr_d  = 1'b0;
      if (stat_o.idx_last) begin
        cnt_d = '0;
      end else begin
        idx_d     = idx_inc;
        ram_re    = 1'b1;
        ram_raddr = idx_inc;
      end
    end

    // Send terminator and drop name state
    if (cmd_i.load_term) begin
      ovld_d  = 1'b1;
      obyte_d = TERM_BYTE;
      olast_d = 1'b1;
      oerr_d  = err_q;
      cnt_d   = '0;
      err_d   = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      err_q  <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      err_q  <= err_d;
      ovld_q <= ovld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
  end

  assign out_valid_o  = ovld_q;
  assign out_byte_o   = obyte_q;
  assign is_last_o    = olast_q;
  assign name_error_o = oerr_q;

endmodule

`default_nettype wire

/* rtl/dnle_ctrl.sv */
// Controller: sequences label collection, label readout and terminator.
`default_nettype none

module dnle_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               cmd_i,
  input  wire dnle_pkg::dp_stat_t stat_i,
  output dnle_pkg::dp_cmd_t       cmd_o
);

  import dnle_pkg::*;

  state_e state_q, state_d;
  logic   term_q, term_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      term_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_END) begin
            term_d  = 1'b1;
            state_d = stat_i.cnt_zero ? ST_TERM : ST_LEN;
          end else if (stat_i.is_dot) begin
            if (stat_i.cnt_zero) begin
              cmd_o.set_err = 1'b1;
            end else begin
              term_d  = 1'b0;
              state_d = ST_LEN;
            end
          end else if (stat_i.cnt_full) begin
            cmd_o.set_err = 1'b1;
          end else begin
            cmd_o.wr_char = 1'b1;
          end
        end
      end
      ST_LEN: begin
        if (stat_i.out_free) begin
          cmd_o.load_len = 1'b1;
          state_d        = ST_CHR;
        end
      end
      ST_CHR: begin
        if (stat_i.out_free) begin
          cmd_o.load_chr = 1'b1;
          if (stat_i.idx_last) begin
            state_d = term_q ? ST_TERM : ST_IDLE;
          end
        end
      end
      ST_TERM: begin
        if (stat_i.out_free) begin
          cmd_o.load_term = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/dns_name_label_encoder.sv */
// Top level of the DNS name label encoder.
//
// Input channel: one request per host name character (cmd_i = 0, byte on
// char_in_i) or an end-of-name request (cmd_i = 1). Output channel: DNS wire
// format bytes, each label as a length byte and its characters, then a zero
// byte flagged by is_last_o, with name_error_o set if an empty label or a
// label longer than MAX_LABEL occurred in that name.
// Throughput: ordinary characters never stall the input. A dot with a
// non-empty label stalls the input while its length byte and N stored
// characters are sent, an end request also while the zero byte follows
// (only that byte with an empty label), one store read per character; the
// registered read is prefetched so one byte leaves per cycle unless the
// receiver stalls. A flush sets the controller state, then loads its first
// byte once the output register is free. Reset clears the label count, error
// flag, controller and output valid flag; the label store is not cleared.
// When the receiver stalls, the output register holds its result and the
// readout waits; characters keep being accepted while no flush is under way.
`default_nettype none

module dns_name_label_encoder #(
  parameter int MAX_LABEL = 62
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       cmd_i,
  input  wire logic [7:0] char_in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            is_last_o,
  output logic            name_error_o
);

  import dnle_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Controller
  dnle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Datapath
  dnle_dp #(
    .MaxLabel (MAX_LABEL)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_in_i    (char_in_i),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .is_last_o    (is_last_o),
    .name_error_o (name_error_o)
  );

endmodule

`default_nettype wire

/* bench/dns_name_label_encoder_tb.sv */
// Self-checking testbench for the DNS name label encoder.
module dns_name_label_encoder_tb;
  import dnle_pkg::*;

  localparam int MAX_LABEL    = 62;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_ITEMS = 130;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
    logic       err;
  } wire_byte_t;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       cmd_i       = CMD_CHAR;
  logic [7:0] char_in_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       is_last_o;
  logic       name_error_o;

  // Encoder state mirror and expected wire bytes
  logic [7:0] label_chars [MAX_LABEL];
  int         label_len;
  logic       name_err_pending;
  wire_byte_t encoded_q [$];

  // Traffic shaping, run bookkeeping
  int          max_gap;
  int          burst_left;
  stall_mode_e stall_mode;
  int          holds_asked;
  int          holds_served;
  int          items_sent;
  int          names_done;
  int          names_flagged;
  int          bytes_checked;
  int          fail_count;
  int          cycle_count;

  dns_name_label_encoder #(
    .MAX_LABEL(MAX_LABEL)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .char_in_i   (char_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .is_last_o   (is_last_o),
    .name_error_o(name_error_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still expected",
               cycle_count, encoded_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Emit the stored label: length byte, then its characters
  function automatic void flush_label();
    encoded_q.push_back('{data: 8'(label_len), is_last: 1'b0, err: 1'b0});
    for (int i = 0; i < label_len; i++) begin
      encoded_q.push_back('{data: label_chars[i], is_last: 1'b0, err: 1'b0});
    end
    label_len = 0;
  endfunction

  // Advance the mirror by one accepted request
  function automatic void predict_encoding(input logic cmd, input logic [7:0] ch);
    if (cmd == CMD_CHAR) begin
      if (ch == DOT_CHAR) begin
        if (label_len == 0) name_err_pending = 1'b1;
        else flush_label();
      end else if (label_len < MAX_LABEL) begin
        label_chars[label_len] = ch;
        label_len++;
      end else begin
        name_err_pending = 1'b1;
      end
    end else begin
      if (label_len != 0) flush_label();
      encoded_q.push_back('{data: TERM_BYTE, is_last: 1'b1, err: name_err_pending});
      if (name_err_pending) names_flagged++;
      names_done++;
      name_err_pending = 1'b0;
    end
  endfunction

  // Offer one request, hold it until accepted, then maybe idle
  task automatic send_request(input logic cmd, input logic [7:0] ch);
    int gap;
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    char_in_i  <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_encoding(cmd, ch);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [7:0] pick_label_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (ch == DOT_CHAR);
    return ch;
  endfunction

  task automatic set_traffic(input int gap_max, input stall_mode_e mode);
    max_gap    = gap_max;
    stall_mode = mode;
  endtask

  // Receiver: long hold on request, otherwise the selected stall pattern
  initial begin : receiver
    int hold_left;
    int phase;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_served != holds_asked) begin
        hold_left = LONG_HOLD;
        holds_served++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_RANDOM: out_stall_i <= ($urandom_range(0, 99) < 35);
          STALL_PATTERN: begin
            phase = (phase + 1) % 7;
            out_stall_i <= (phase < 3);
          end
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // Compare each accepted result against the oldest expected byte
  always @(posedge clk_i) begin : check_results
    wire_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (encoded_q.size() == 0) begin
        $display("%0t: unexpected result byte=%h is_last=%b name_error=%b",
                 $time, out_byte_o, is_last_o, name_error_o);
        fail_count++;
      end else begin
        want = encoded_q.pop_front();
        bytes_checked++;
        if (out_byte_o !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte_o);
          fail_count++;
        end
        if (is_last_o !== want.is_last) begin
          $display("%0t: is_last expected %b actual %b", $time, want.is_last, is_last_o);
          fail_count++;
        end
        if (name_error_o !== want.err) begin
          $display("%0t: name_error expected %b actual %b", $time, want.err, name_error_o);
          fail_count++;
        end
      end
    end
  end

  // Empty names, byte extremes, leading, doubled and trailing dots
  task automatic test_directed();
    set_traffic(0, STALL_NONE);
    send_request(CMD_END, 8'h00);
    send_request(CMD_END, 8'hFF);
    send_request(CMD_CHAR, 8'h00);
    send_request(CMD_CHAR, 8'hFF);
    send_request(CMD_END, DOT_CHAR);
    send_request(CMD_CHAR, DOT_CHAR);
    send_request(CMD_CHAR, 8'h61);
    send_request(CMD_END, 8'h00);
    send_request(CMD_CHAR, 8'h61);
    send_request(CMD_CHAR, DOT_CHAR);
    send_request(CMD_CHAR, DOT_CHAR);
    send_request(CMD_CHAR, 8'h62);
    send_request(CMD_END, 8'h55);
    send_request(CMD_CHAR, 8'h2D);
    send_request(CMD_CHAR, 8'h2F);
    send_request(CMD_CHAR, DOT_CHAR);
    send_request(CMD_END, 8'hAA);
    send_request(CMD_CHAR, DOT_CHAR);
    send_request(CMD_END, 8'h00);
  endtask

  // Label exactly at the limit, then two past it with truncation
  task automatic test_label_limits();
    set_traffic(2, STALL_RANDOM);
    repeat (MAX_LABEL) send_request(CMD_CHAR, pick_label_char());
    send_request(CMD_END, 8'h00);
    repeat (MAX_LABEL + 2) send_request(CMD_CHAR, pick_label_char());
    send_request(CMD_CHAR, DOT_CHAR);
    send_request(CMD_CHAR, 8'h7A);
    send_request(CMD_END, 8'h00);
  endtask

  // Mostly well-formed names with random content, some noise
  task automatic test_random_names();
    int start;
    int labels;
    int len;
    int noise_len;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0: set_traffic(0, STALL_NONE);
        1: set_traffic(3, STALL_RANDOM);
        2: set_traffic(8, STALL_PATTERN);
        3: set_traffic(0, STALL_RANDOM);
        default: set_traffic(5, STALL_NONE);
      endcase
      if ($urandom_range(0, 5) == 0) begin
        // Noise: arbitrary characters, stray dots and end requests
        noise_len = $urandom_range(1, 12);
        repeat (noise_len) begin
          if ($urandom_range(0, 7) == 0)
            send_request(CMD_END, 8'($urandom_range(0, 255)));
          else if ($urandom_range(0, 3) == 0)
            send_request(CMD_CHAR, DOT_CHAR);
          else
            send_request(CMD_CHAR, 8'($urandom_range(0, 255)));
        end
      end else begin
        labels = $urandom_range(1, 4);
        for (int l = 0; l < labels; l++) begin
          len = ($urandom_range(0, 24) == 0) ? $urandom_range(55, 68) : $urandom_range(1, 6);
          repeat (len) send_request(CMD_CHAR, pick_label_char());
          if (l != labels - 1 || $urandom_range(0, 5) == 0) send_request(CMD_CHAR, DOT_CHAR);
        end
      end
      send_request(CMD_END, 8'($urandom_range(0, 255)));
    end
  endtask

  // Hold the receiver off while names keep coming, so the input stalls
  task automatic test_backpressure();
    set_traffic(0, STALL_NONE);
    holds_asked++;
    repeat (3) begin
      repeat (2) begin
        repeat (10) send_request(CMD_CHAR, pick_label_char());
        send_request(CMD_CHAR, DOT_CHAR);
      end
      send_request(CMD_END, 8'h00);
    end
  endtask

  initial begin
    label_len        = 0;
    name_err_pending = 1'b0;
    max_gap          = 0;
    burst_left       = 0;
    stall_mode       = STALL_NONE;
    holds_asked      = 0;
    holds_served     = 0;
    items_sent       = 0;
    names_done       = 0;
    names_flagged    = 0;
    bytes_checked    = 0;
    fail_count       = 0;
    cycle_count      = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_label_limits();
    test_backpressure();
    test_random_names();

    // Drain outstanding results
    in_valid_i <= 1'b0;
    set_traffic(0, STALL_RANDOM);
    wait (encoded_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests forming %0d names (%0d flagged with label errors)",
             items_sent, names_done, names_flagged);
    $display("Checked %0d encoded bytes under bursty input, stalls and a %0d-cycle hold",
             bytes_checked, LONG_HOLD);
    if (fail_count == 0 && encoded_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
